/* design/adfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adfr_pkg
// Shared types and constants of the API frame receive deframer.
// ----------------------------------------------------------------------------
package adfr_pkg;

    localparam logic [7:0]  START_DELIM       = 8'h7E;
    localparam logic [7:0]  CKS_BASE          = 8'hFF;
    localparam logic [7:0]  MIN_OFFSET        = 8'd4;
    localparam logic [7:0]  RESET_FRAME_TYPE  = 8'h91;
    localparam logic [7:0]  RESET_OFFSET      = 8'd21;
    localparam logic [15:0] RESET_MAX_PAYLOAD = 16'd256;
    localparam int          QUEUE_DEPTH       = 4;

    // configuration register indexes
    localparam logic [1:0] REG_FRAME_TYPE  = 2'd0;
    localparam logic [1:0] REG_OFFSET      = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    typedef enum logic [1:0] {
        STAT_GOOD      = 2'd0,
        STAT_BAD_CKS   = 2'd1,
        STAT_TOO_LONG  = 2'd2,
        STAT_TOO_SHORT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_LEN_HI = 4'b0010,
        PH_LEN_LO = 4'b0100,
        PH_BODY   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic        emit;
        status_t     err;
        logic [15:0] count;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [7:0]  offset;
        logic [15:0] max_payload;
    } cfg_t;

endpackage
`default_nettype wire

/* design/api_frame_rx_deframer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// api_frame_rx_deframer
// Receive-side API frame deframer with payload streaming and status words.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. The parser hunts for the 0x7E delimiter,
// reads the big-endian length, checks the frame type and header limits, and
// queues commands; the output side keeps the checksum sum and emits payload
// words and one end word (status and payload count) per accepted frame.
// Frames of another type produce no words. Throughput is one byte per cycle:
// in_stall rises only when the QUEUE_DEPTH-entry command queue is full, which
// happens only while out_stall holds the output register. A byte's word goes
// via the command queue and the output register. Configuration is always
// ready (cfg_ready is tied high); write only while no frame is in flight.
module api_frame_rx_deframer #(
    parameter int QUEUE_DEPTH = adfr_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             is_end,
    output logic [1:0]       frame_status,
    output logic [15:0]      payload_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import adfr_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t push_cmd, pop_cmd;
    logic push, pop, q_full, q_avail;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_TYPE:  cfg_next.frame_type  = cfg_data[7:0];
                REG_OFFSET:      cfg_next.offset      = cfg_data[7:0];
                REG_MAX_PAYLOAD: cfg_next.max_payload = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_type  <= RESET_FRAME_TYPE;
            cfg_reg.offset      <= RESET_OFFSET;
            cfg_reg.max_payload <= RESET_MAX_PAYLOAD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = q_full;

    adfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .cfg      (cfg_reg),
        .cmd      (push_cmd),
        .cmd_push (push)
    );

    adfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .not_empty (q_avail)
    );

    adfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (pop_cmd),
        .cmd_avail     (q_avail),
        .cmd_pop       (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .is_end        (is_end),
        .frame_status  (frame_status),
        .payload_count (payload_count)
    );

endmodule
`default_nettype wire

/* design/adfr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adfr_front
// Byte parser: delimiter hunt, length, header checks, and command issue.
// ----------------------------------------------------------------------------
module adfr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_stall,
    input  wire logic [7:0]     rx_byte,
    input  wire adfr_pkg::cfg_t cfg,
    output adfr_pkg::cmd_t      cmd,
    output logic                cmd_push
);
    import adfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic        skip_reg, skip_next;
    status_t     err_reg, err_next;

    logic        accept;
    logic [7:0]  eff_off;
    logic [15:0] full_len;
    logic [16:0] hdr_cks;
    logic [16:0] hdr_diff;
    status_t     hdr_err;
    logic [16:0] end_cks;
    logic [16:0] end_diff;
    logic [15:0] end_count;
    logic [16:0] abs_pos;
    logic        skip_eff;

    assign accept   = in_valid && !in_stall;
    assign eff_off  = (cfg.offset < MIN_OFFSET) ? MIN_OFFSET : cfg.offset;

    // header checks on the full length as the low byte arrives
    assign full_len = {len_reg[15:8], rx_byte};
    assign hdr_cks  = {1'b0, full_len} + 17'd3;
    assign hdr_diff = hdr_cks - {9'd0, eff_off};

    always_comb
    begin
        if (hdr_cks < {9'd0, eff_off})
            hdr_err = STAT_TOO_SHORT;
        else if (hdr_diff >= {1'b0, cfg.max_payload})
            hdr_err = STAT_TOO_LONG;
        else
            hdr_err = STAT_GOOD;
    end

    // payload count from the live offset
    assign end_cks   = {1'b0, len_reg} + 17'd3;
    assign end_diff  = end_cks - {9'd0, eff_off};
    assign end_count = (end_cks >= {9'd0, eff_off}) ? end_diff[15:0] : 16'd0;
    assign abs_pos   = {1'b0, pos_reg} + 17'd3;
    assign skip_eff  = skip_reg || ((pos_reg == 16'd0) && (rx_byte != cfg.frame_type));

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        skip_next  = skip_reg;
        err_next   = err_reg;
        cmd_push   = 1'b0;
        cmd.kind   = CMD_START;
        cmd.data   = rx_byte;
        cmd.emit   = 1'b0;
        cmd.err    = err_reg;
        cmd.count  = 16'd0;
        if (accept)
        begin
            case (phase_reg)
                PH_LEN_HI:
                begin
                    len_next   = {rx_byte, 8'd0};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = full_len;
                    pos_next   = 16'd0;
                    skip_next  = 1'b0;
                    err_next   = hdr_err;
                    phase_next = PH_BODY;
                    cmd_push   = 1'b1;
                    cmd.kind   = CMD_START;
                end
                PH_BODY:
                begin
                    if (pos_reg == len_reg)
                    begin
                        phase_next = PH_HUNT;
                        cmd_push   = !skip_reg;
                        cmd.kind   = CMD_END;
                        cmd.count  = (err_reg == STAT_TOO_SHORT) ? 16'd0 : end_count;
                    end
                    else
                    begin
                        skip_next = skip_eff;
                        pos_next  = pos_reg + 16'd1;
                        cmd_push  = !skip_eff;
                        cmd.kind  = CMD_DATA;
                        cmd.emit  = (err_reg == STAT_GOOD) && (abs_pos >= {9'd0, eff_off});
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == START_DELIM) ? PH_LEN_HI : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 16'd0;
            len_reg   <= 16'd0;
            skip_reg  <= 1'b0;
            err_reg   <= STAT_GOOD;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            skip_reg  <= skip_next;
            err_reg   <= err_next;
        end
    end

endmodule
`default_nettype wire

/* design/adfr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adfr_queue
// Short command queue between the parser and the output side.
// ----------------------------------------------------------------------------
module adfr_queue #(
    parameter int DEPTH = adfr_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire adfr_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output adfr_pkg::cmd_t      pop_cmd,
    output logic                not_empty
);
    import adfr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] LIMIT = CW'(DEPTH);

    cmd_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == LIMIT);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? ((wr_reg == LAST) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop  ? ((rd_reg == LAST) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

/* design/adfr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adfr_back
// Checksum accumulation, status decision and the output word register.
// ----------------------------------------------------------------------------
module adfr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire adfr_pkg::cmd_t cmd,
    input  wire logic           cmd_avail,
    output logic                cmd_pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_byte,
    output logic                is_end,
    output logic [1:0]          frame_status,
    output logic [15:0]         payload_count
);
    import adfr_pkg::*;

    logic [7:0]  sum_reg, sum_next;
    logic        vld_reg, vld_next;
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;
    status_t     stat_reg, stat_next;
    logic [15:0] cnt_reg, cnt_next;

    logic        needs_out;
    logic        slot_free;
    logic [7:0]  expect_cks;

    assign needs_out  = (cmd.kind == CMD_END) || ((cmd.kind == CMD_DATA) && cmd.emit);
    assign slot_free  = !vld_reg || !out_stall;
    assign cmd_pop    = cmd_avail && (!needs_out || slot_free);
    assign expect_cks = CKS_BASE - sum_reg;

    always_comb
    begin
        sum_next  = sum_reg;
        vld_next  = vld_reg && out_stall;
        byte_next = byte_reg;
        end_next  = end_reg;
        stat_next = stat_reg;
        cnt_next  = cnt_reg;
        if (cmd_pop)
        begin
            case (cmd.kind)
                CMD_START:
                begin
                    sum_next = 8'd0;
                end
                CMD_DATA:
                begin
                    sum_next = sum_reg + cmd.data;
                    if (cmd.emit)
                    begin
                        vld_next  = 1'b1;
                        byte_next = cmd.data;
                        end_next  = 1'b0;
                        stat_next = STAT_GOOD;
                        cnt_next  = 16'd0;
                    end
                end
                CMD_END:
                begin
                    vld_next  = 1'b1;
                    byte_next = 8'd0;
                    end_next  = 1'b1;
                    cnt_next  = cmd.count;
                    // header errors win over the checksum result
                    if (cmd.err != STAT_GOOD)
                        stat_next = cmd.err;
                    else if (expect_cks == cmd.data)
                        stat_next = STAT_GOOD;
                    else
                        stat_next = STAT_BAD_CKS;
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 8'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
        stat_reg <= stat_next;
        cnt_reg  <= cnt_next;
    end

    assign out_valid     = vld_reg;
    assign out_byte      = byte_reg;
    assign is_end        = end_reg;
    assign frame_status  = stat_reg;
    assign payload_count = cnt_reg;

endmodule
`default_nettype wire
